// File: rtl/core/bpf_pkg.sv
// ============================================================================
// bpf_pkg
// Shared types and constants of the Bezier path flattener: request and point
// payloads, sequencer states and the control link to the iterative unit.
// ============================================================================
`default_nettype none

package bpf_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int STEP_W   = 16;
    localparam int CFG_W    = 8;
    // curve parameter t, unsigned Q0.16 held in 17 bits so t = 1 is exact
    localparam int T_W      = 17;
    localparam int T_ONE    = 65536;
    // control points in Q.8
    localparam int Q8_W     = COORD_W + 8;
    // squared chord length and its root
    localparam int RAD_W    = 50;
    localparam int ROOT_W   = 25;
    localparam int ROOT_STEPS = RAD_W / 2;
    // shared multiplier operands
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 26;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd200;

    // request types
    localparam logic [1:0] REQ_MOVE  = 2'd0;
    localparam logic [1:0] REQ_LINE  = 2'd1;
    localparam logic [1:0] REQ_QUAD  = 2'd2;
    localparam logic [1:0] REQ_CUBIC = 2'd3;

    // register indexes
    localparam logic [CFG_W-1:0] CFG_CONIC = 8'd0;
    localparam logic [CFG_W-1:0] CFG_CUBIC = 8'd1;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic                      pen_down;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      saturated;
        logic                      last;
    } t_pt;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TNEXT,
        S_LOADW,
        S_LERP,
        S_ROUND,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_ROOTW,
        S_DIV,
        S_DIVW,
        S_RECIP,
        S_RECIPW
    } t_state;

    typedef enum logic {
        ITER_SQRT,
        ITER_DIV
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

endpackage

`default_nettype wire

// File: rtl/core/bezier_path_flattener.sv
// ============================================================================
// bezier_path_flattener
// Flattens move, line, quadratic and cubic outline commands into points,
// with curve segment counts taken from a chord-sum length estimate.
// ============================================================================
//
//  channel | direction | signals                      | payload
//  --------+-----------+------------------------------+----------------------
//  request | in        | i_req_valid / o_req_ready    | i_req (t_req)
//  point   | out       | o_pt_valid / i_pt_ready      | o_pt (t_pt)
//  config  | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  Move or line: the point is registered on acceptance and shown the next cycle.
//  Curve: LENGTH_SAMPLES chords are measured, each as two coordinates of L
//  lerps, two squares and a root; then two divisions; then two coordinates of
//  L lerps per point, with L = 3 lerps for a quadratic and 6 for a cubic.
//  One shared multiplier does one lerp a cycle. Synchronous active-low reset
//  clears the sequencer and pen, and sets the step registers to STEP_RESET.
//  A stalled point output holds the sequencer until the point is taken.
// ============================================================================
`default_nettype none

module bezier_path_flattener import bpf_pkg::*; #(
    parameter int MAX_SEGMENTS   = 64,
    parameter int LENGTH_SAMPLES = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_req              i_req,
    output logic              o_pt_valid,
    input  logic              i_pt_ready,
    output t_pt               o_pt,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [STEP_W-1:0] i_cfg_data
);

    localparam int CNT_MAX = (MAX_SEGMENTS > LENGTH_SAMPLES) ? MAX_SEGMENTS : LENGTH_SAMPLES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int LEN_W   = ROOT_W + $clog2(LENGTH_SAMPLES);
    localparam int LS_Q0   = T_ONE / LENGTH_SAMPLES;
    localparam int LS_R0   = T_ONE % LENGTH_SAMPLES;
    localparam int DX_W    = COORD_W + 1;

    t_state r_state, n_state;

    // configuration and pen
    logic [STEP_W-1:0]         r_conic;
    logic [STEP_W-1:0]         r_cubic;
    logic signed [COORD_W-1:0] r_pen_x;
    logic signed [COORD_W-1:0] r_pen_y;

    // curve under work
    logic signed [COORD_W-1:0] r_cx [4];
    logic signed [COORD_W-1:0] r_cy [4];
    logic                      r_cubic_req;
    logic [STEP_W-1:0]         r_step;

    // de Casteljau queue
    logic signed [Q8_W-1:0]    r_q [4];
    logic signed [Q8_W-1:0]    n_q [4];
    logic [1:0]                r_lvl;
    logic [1:0]                r_s;
    logic                      r_coord;
    logic                      r_meas;

    // t generator: T = floor((k*65536 + d/2) / d), stepped incrementally
    logic [T_W-1:0]            r_tq;
    logic [T_W-1:0]            r_tq0;
    logic [CNT_W-1:0]          r_tr;
    logic [CNT_W-1:0]          r_tr0;
    logic [CNT_W-1:0]          r_td;

    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          r_n;
    logic                      r_sat;

    logic signed [COORD_W-1:0] r_sx, r_sy, r_lx, r_ly;
    logic [RAD_W-1:0]          r_sq;
    logic [LEN_W-1:0]          r_len;

    t_pt                       r_out;
    logic                      r_ov;

    // combinational
    logic                      req_fire;
    logic                      out_free;
    logic                      is_curve;
    logic                      mv_load;
    logic                      pt_load;
    logic                      last_pt;
    logic                      lvl_final;
    logic signed [Q8_W:0]      diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [MUL_P_W-1:0] lerp_sh;
    logic signed [Q8_W-1:0]    lerp_new;
    logic [Q8_W:0]             rnd_sum;
    logic signed [COORD_W-1:0] rnd_val;
    logic signed [DX_W-1:0]    dx, dy;
    logic [CNT_W:0]            tr_sum;
    logic                      tr_wrap;
    logic [STEP_W-1:0]         step_sel;
    logic                      seg_lo, seg_hi;

    t_iter_ctl                 iter_ctl;
    t_iter_sts                 iter_sts;
    logic [LEN_W-1:0]          iter_dvd;
    logic [STEP_W-1:0]         iter_dvs;
    logic [ROOT_W-1:0]         iter_root;
    logic [LEN_W-1:0]          iter_quo;
    logic [STEP_W-1:0]         iter_rem;

    bpf_iter #(
        .DVD_W (LEN_W)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (iter_ctl),
        .i_rad   (r_sq),
        .i_dvd   (iter_dvd),
        .i_dvs   (iter_dvs),
        .o_sts   (iter_sts),
        .o_root  (iter_root),
        .o_quo   (iter_quo),
        .o_rem   (iter_rem)
    );

    // handshake helpers
    assign out_free = !r_ov || i_pt_ready;
    assign req_fire = i_req_valid && o_req_ready;
    assign is_curve = (i_req.req_type == REQ_QUAD) || (i_req.req_type == REQ_CUBIC);
    assign mv_load  = req_fire && !is_curve;
    assign last_pt  = r_cnt == r_n;
    assign pt_load  = (r_state == S_ROUND) && r_coord && !r_meas && out_free;
    assign lvl_final = r_s == 2'(r_lvl - 2'd1);

    // shared multiplier: lerp difference times t, or a chord delta squared
    always_comb begin
        diff = {r_q[1][Q8_W-1], r_q[1]} - {r_q[0][Q8_W-1], r_q[0]};
        dx   = {r_sx[COORD_W-1], r_sx} - {r_lx[COORD_W-1], r_lx};
        dy   = {r_sy[COORD_W-1], r_sy} - {r_ly[COORD_W-1], r_ly};
        if (r_state == S_LERP) begin
            mul_a = {{(MUL_A_W-Q8_W-1){diff[Q8_W]}}, diff};
            mul_b = {{(MUL_B_W-T_W){1'b0}}, r_tq};
        end else if (r_state == S_SQY) begin
            mul_a = {{(MUL_A_W-DX_W){dy[DX_W-1]}}, dy};
            mul_b = {{(MUL_B_W-DX_W){dy[DX_W-1]}}, dy};
        end else begin
            mul_a = {{(MUL_A_W-DX_W){dx[DX_W-1]}}, dx};
            mul_b = {{(MUL_B_W-DX_W){dx[DX_W-1]}}, dx};
        end
        prod     = mul_a * mul_b;
        lerp_sh  = (prod + MUL_P_W'(32768)) >>> 16;
        lerp_new = r_q[0] + lerp_sh[Q8_W-1:0];
        rnd_sum  = {r_q[0][Q8_W-1], r_q[0]} + (Q8_W+1)'(128);
        rnd_val  = rnd_sum[Q8_W-1:8];
    end

    // queue update for one lerp
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_q[i] = r_q[i];
        end
        if (lvl_final) begin
            for (int i = 0; i < 2; i++) begin
                n_q[i] = r_q[i+2];
            end
            n_q[2'(r_lvl - 2'd1)] = lerp_new;
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_q[i] = r_q[i+1];
            end
            n_q[r_lvl] = lerp_new;
        end
    end

    // t step and segment clamp
    always_comb begin
        tr_sum   = {1'b0, r_tr} + {1'b0, r_tr0};
        tr_wrap  = tr_sum >= {1'b0, r_td};
        step_sel = (i_req.req_type == REQ_QUAD) ? r_conic : r_cubic;
        seg_lo   = iter_quo < LEN_W'(2);
        seg_hi   = iter_quo > LEN_W'(MAX_SEGMENTS);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and unit control
    always_comb begin
        n_state        = r_state;
        o_req_ready    = 1'b0;
        iter_ctl.start = 1'b0;
        iter_ctl.mode  = ITER_DIV;
        iter_dvd       = LEN_W'(T_ONE);
        iter_dvs       = STEP_W'(r_n);
        case (r_state)
            S_IDLE: begin
                o_req_ready = out_free;
                if (req_fire && is_curve) n_state = S_TNEXT;
            end
            S_TNEXT: n_state = S_LOADW;
            S_LOADW: n_state = S_LERP;
            S_LERP: begin
                if (lvl_final && r_lvl == 2'd1) n_state = S_ROUND;
            end
            S_ROUND: begin
                if (!r_coord) begin
                    n_state = S_LOADW;
                end else if (r_meas) begin
                    n_state = S_SQX;
                end else if (out_free) begin
                    n_state = last_pt ? S_IDLE : S_TNEXT;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_ROOT;
            S_ROOT: begin
                iter_ctl.start = 1'b1;
                iter_ctl.mode  = ITER_SQRT;
                n_state        = S_ROOTW;
            end
            S_ROOTW: begin
                if (iter_sts.done) begin
                    n_state = (r_cnt == CNT_W'(LENGTH_SAMPLES)) ? S_DIV : S_TNEXT;
                end
            end
            S_DIV: begin
                iter_ctl.start = 1'b1;
                iter_dvd       = r_len;
                iter_dvs       = r_step;
                n_state        = S_DIVW;
            end
            S_DIVW: begin
                if (iter_sts.done) n_state = S_RECIP;
            end
            S_RECIP: begin
                iter_ctl.start = 1'b1;
                n_state        = S_RECIPW;
            end
            S_RECIPW: begin
                if (iter_sts.done) n_state = S_TNEXT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // step registers, pen and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conic <= STEP_RESET;
            r_cubic <= STEP_RESET;
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CONIC: r_conic <= i_cfg_data;
                    CFG_CUBIC: r_cubic <= i_cfg_data;
                    default: ;
                endcase
            end
            if (mv_load) begin
                r_ov    <= 1'b1;
                r_pen_x <= i_req.end_x;
                r_pen_y <= i_req.end_y;
            end else if (pt_load) begin
                r_ov <= 1'b1;
                if (last_pt) begin
                    r_pen_x <= r_cx[3];
                    r_pen_y <= r_cy[3];
                end
            end else if (i_pt_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output point
    always_ff @(posedge i_clk) begin
        if (mv_load) begin
            r_out <= '{pen_down: i_req.req_type == REQ_LINE, point_x: i_req.end_x,
                       point_y: i_req.end_y, saturated: 1'b0, last: 1'b1};
        end else if (pt_load) begin
            r_out <= '{pen_down: 1'b1, point_x: r_sx, point_y: rnd_val,
                       saturated: r_sat, last: last_pt};
        end
    end

    // curve datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    r_cx[0] <= r_pen_x;
                    r_cy[0] <= r_pen_y;
                    r_cx[1] <= i_req.ctrl1_x;
                    r_cy[1] <= i_req.ctrl1_y;
                    r_cx[2] <= (i_req.req_type == REQ_QUAD) ? i_req.end_x : i_req.ctrl2_x;
                    r_cy[2] <= (i_req.req_type == REQ_QUAD) ? i_req.end_y : i_req.ctrl2_y;
                    r_cx[3] <= i_req.end_x;
                    r_cy[3] <= i_req.end_y;
                    r_cubic_req <= i_req.req_type == REQ_CUBIC;
                    r_step  <= (step_sel == '0) ? STEP_W'(1) : step_sel;
                    r_td    <= CNT_W'(LENGTH_SAMPLES);
                    r_tq0   <= T_W'(LS_Q0);
                    r_tr0   <= CNT_W'(LS_R0);
                    r_tq    <= '0;
                    r_tr    <= CNT_W'(LENGTH_SAMPLES / 2);
                    r_cnt   <= CNT_W'(1);
                    r_meas  <= 1'b1;
                    r_len   <= '0;
                    r_lx    <= r_pen_x;
                    r_ly    <= r_pen_y;
                    r_sat   <= 1'b0;
                end
            end
            S_TNEXT: begin
                r_coord <= 1'b0;
                if (tr_wrap) begin
                    r_tr <= CNT_W'(tr_sum - {1'b0, r_td});
                    r_tq <= r_tq + r_tq0 + T_W'(1);
                end else begin
                    r_tr <= tr_sum[CNT_W-1:0];
                    r_tq <= r_tq + r_tq0;
                end
            end
            S_LOADW: begin
                for (int i = 0; i < 4; i++) begin
                    r_q[i] <= r_coord ? {r_cy[i], 8'h00} : {r_cx[i], 8'h00};
                end
                r_lvl <= r_cubic_req ? 2'd3 : 2'd2;
                r_s   <= '0;
            end
            S_LERP: begin
                for (int i = 0; i < 4; i++) begin
                    r_q[i] <= n_q[i];
                end
                if (lvl_final) begin
                    r_lvl <= r_lvl - 2'd1;
                    r_s   <= '0;
                end else begin
                    r_s <= r_s + 2'd1;
                end
            end
            S_ROUND: begin
                if (!r_coord) begin
                    r_sx    <= rnd_val;
                    r_coord <= 1'b1;
                end else if (r_meas) begin
                    r_sy <= rnd_val;
                end else if (out_free && !last_pt) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_SQX: r_sq <= prod[RAD_W-1:0];
            S_SQY: r_sq <= r_sq + prod[RAD_W-1:0];
            S_ROOTW: begin
                if (iter_sts.done) begin
                    r_len <= r_len + LEN_W'(iter_root);
                    r_lx  <= r_sx;
                    r_ly  <= r_sy;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_DIVW: begin
                if (iter_sts.done) begin
                    if (seg_lo) begin
                        r_n <= CNT_W'(2);
                    end else if (seg_hi) begin
                        r_n   <= CNT_W'(MAX_SEGMENTS);
                        r_sat <= 1'b1;
                    end else begin
                        r_n <= iter_quo[CNT_W-1:0];
                    end
                end
            end
            S_RECIPW: begin
                if (iter_sts.done) begin
                    r_tq0  <= iter_quo[T_W-1:0];
                    r_tr0  <= iter_rem[CNT_W-1:0];
                    r_td   <= r_n;
                    r_tq   <= '0;
                    r_tr   <= r_n >> 1;
                    r_cnt  <= CNT_W'(1);
                    r_meas <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_pt_valid  = r_ov;
    assign o_pt        = r_out;
    assign o_cfg_ready = 1'b1;

    // checks
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_ctl.start |-> !iter_sts.busy)
        else $error("iterative unit started while busy");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_sts.done |-> (r_state == S_ROOTW || r_state == S_DIVW || r_state == S_RECIPW))
        else $error("iterative result arrived with no state waiting");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TNEXT && !r_meas) |->
            (r_n >= CNT_W'(2) && r_n <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LERP) |-> (r_tq <= T_W'(T_ONE) && r_tr < r_td))
        else $error("curve parameter beyond one");

endmodule

`default_nettype wire

// File: rtl/core/bpf_iter.sv
// ============================================================================
// bpf_iter
// Iterative root and divide unit: integer square root two bits per cycle,
// or restoring division one quotient bit per cycle.
// ============================================================================
`default_nettype none

module bpf_iter import bpf_pkg::*; #(
    parameter int DVD_W = 29
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_iter_ctl          i_ctl,
    input  logic [RAD_W-1:0]   i_rad,
    input  logic [DVD_W-1:0]   i_dvd,
    input  logic [STEP_W-1:0]  i_dvs,
    output t_iter_sts          o_sts,
    output logic [ROOT_W-1:0]  o_root,
    output logic [DVD_W-1:0]   o_quo,
    output logic [STEP_W-1:0]  o_rem
);

    localparam int STEPS_MAX = (DVD_W > ROOT_STEPS) ? DVD_W : ROOT_STEPS;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    logic             r_busy;
    logic             r_done;
    t_iter_mode       r_mode;
    logic [CNT_W-1:0] r_cnt;

    logic [RAD_W-1:0]  r_v;
    logic [RAD_W-1:0]  r_res;
    logic [RAD_W-1:0]  r_bit;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W-1:0] r_dvs;

    logic [RAD_W-1:0]  sq_try;
    logic              sq_ge;
    logic [STEP_W:0]   rem_sh;
    logic [STEP_W:0]   rem_sub;
    logic              dv_ge;

    // root trial and divide trial
    always_comb begin
        sq_try  = r_res + r_bit;
        sq_ge   = r_v >= sq_try;
        rem_sh  = {r_rem, r_v[DVD_W-1]};
        dv_ge   = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= ITER_SQRT;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_mode <= i_ctl.mode;
                r_cnt  <= (i_ctl.mode == ITER_SQRT) ? CNT_W'(ROOT_STEPS) : CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            if (i_ctl.mode == ITER_SQRT) begin
                r_v   <= i_rad;
                r_res <= '0;
                r_bit <= RAD_W'(1) << (RAD_W - 2);
            end else begin
                r_v   <= RAD_W'(i_dvd);
                r_rem <= '0;
                r_dvs <= i_dvs;
            end
        end else if (r_busy) begin
            if (r_mode == ITER_SQRT) begin
                if (sq_ge) begin
                    r_v   <= r_v - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_rem <= dv_ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
                r_v   <= {r_v[RAD_W-2:0], dv_ge};
            end
        end
    end

    assign o_sts  = '{busy: r_busy, done: r_done};
    assign o_root = r_res[ROOT_W-1:0];
    assign o_quo  = r_v[DVD_W-1:0];
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: verif/tb_bezier_path_flattener.sv
// ============================================================================
// tb_bezier_path_flattener
// Self-checking bench for the Bezier path flattener: a directed table of
// requests, then random paths under three idle profiles and step settings,
// every point checked against a bit-accurate flattening model.
// ============================================================================
`default_nettype none

module tb_bezier_path_flattener import bpf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEG  = 64;
    localparam int N_SAMP   = 10;
    localparam int WDOG_MAX = 20000;
    localparam int TAIL_CYC = 100;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    t_req              req;
    logic              pt_valid;
    logic              pt_ready;
    t_pt               pt;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index;
    logic [STEP_W-1:0] cfg_data;

    bezier_path_flattener #(
        .MAX_SEGMENTS   (MAX_SEG),
        .LENGTH_SAMPLES (N_SAMP)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_pt_valid  (pt_valid),
        .i_pt_ready  (pt_ready),
        .o_pt        (pt),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // model state
    logic [STEP_W-1:0]         mdl_conic_step;
    logic [STEP_W-1:0]         mdl_cubic_step;
    logic signed [COORD_W-1:0] mdl_pen_x;
    logic signed [COORD_W-1:0] mdl_pen_y;

    t_pt    pending_pts[$];
    int     n_err;
    int     n_mism;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     recv_hold;
    int     hold_cycles;
    int     quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // flattening model
    // ------------------------------------------------------------------------
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint lerp8(longint a, longint b, longint t);
        return a + floor_sh((b - a) * t + 32768, 16);
    endfunction

    function automatic longint curve_at(longint p[4], int cnt, longint t);
        longint w[4];
        w = p;
        for (int lvl = cnt - 1; lvl > 0; lvl--)
            for (int i = 0; i < lvl; i++)
                w[i] = lerp8(w[i], w[i+1], t);
        return floor_sh(w[0] + 128, 8);
    endfunction

    function automatic longint t_of(longint k, longint d);
        return (k * 65536 + d / 2) / d;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r = 0;
        longint b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic flatten_request(input t_req r);
        longint px[4], py[4];
        longint lx, ly, sx, sy, dx, dy, len, stp, nseg, tt;
        int     cnt;
        bit     sat;
        t_pt    p;
        if (r.req_type == REQ_MOVE || r.req_type == REQ_LINE) begin
            p.pen_down  = (r.req_type == REQ_LINE);
            p.point_x   = r.end_x;
            p.point_y   = r.end_y;
            p.saturated = 1'b0;
            p.last      = 1'b1;
            pending_pts.push_back(p);
        end else begin
            px[0] = longint'(mdl_pen_x) * 256;
            py[0] = longint'(mdl_pen_y) * 256;
            px[1] = longint'(r.ctrl1_x) * 256;
            py[1] = longint'(r.ctrl1_y) * 256;
            if (r.req_type == REQ_QUAD) begin
                cnt = 3;
                px[2] = longint'(r.end_x) * 256;
                py[2] = longint'(r.end_y) * 256;
                px[3] = 0;
                py[3] = 0;
                stp = mdl_conic_step;
            end else begin
                cnt = 4;
                px[2] = longint'(r.ctrl2_x) * 256;
                py[2] = longint'(r.ctrl2_y) * 256;
                px[3] = longint'(r.end_x) * 256;
                py[3] = longint'(r.end_y) * 256;
                stp = mdl_cubic_step;
            end
            if (stp == 0) stp = 1;
            // chord-sum length estimate
            lx = mdl_pen_x;
            ly = mdl_pen_y;
            len = 0;
            for (int j = 1; j <= N_SAMP; j++) begin
                tt = t_of(j, N_SAMP);
                sx = curve_at(px, cnt, tt);
                sy = curve_at(py, cnt, tt);
                dx = sx - lx;
                dy = sy - ly;
                len += int_sqrt(dx * dx + dy * dy);
                lx = sx;
                ly = sy;
            end
            nseg = len / stp;
            sat = 1'b0;
            if (nseg < 2) nseg = 2;
            if (nseg > MAX_SEG) begin
                nseg = MAX_SEG;
                sat = 1'b1;
            end
            for (int k = 1; k <= nseg; k++) begin
                tt = t_of(k, nseg);
                p.pen_down  = 1'b1;
                p.point_x   = COORD_W'(curve_at(px, cnt, tt));
                p.point_y   = COORD_W'(curve_at(py, cnt, tt));
                p.saturated = sat;
                p.last      = (k == nseg);
                pending_pts.push_back(p);
            end
        end
        mdl_pen_x = r.end_x;
        mdl_pen_y = r.end_y;
    endtask

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------
    // valid stays up after an accept so requests can follow back to back;
    // it drops only for sender idle cycles or a drain
    task automatic send_request(input t_req r);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk);
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        flatten_request(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
    endtask

    task automatic write_step(input logic [CFG_W-1:0] idx, input logic [STEP_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CONIC) mdl_conic_step = val;
        else if (idx == CFG_CUBIC) mdl_cubic_step = val;
        @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(int span);
        case ($urandom_range(9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return COORD_W'($urandom);
            default: return COORD_W'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic t_req rand_request(int span);
        t_req r;
        r.req_type = 2'($urandom_range(3));
        r.ctrl1_x  = rand_coord(span);
        r.ctrl1_y  = rand_coord(span);
        r.ctrl2_x  = rand_coord(span);
        r.ctrl2_y  = rand_coord(span);
        r.end_x    = rand_coord(span);
        r.end_y    = rand_coord(span);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // point checking and receiver idling
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (pt_valid && pt_ready) begin
                if (pending_pts.size() == 0) begin
                    n_err++;
                    if (n_mism++ < 10)
                        $display("unexpected point %p", pt);
                end else begin
                    t_pt e;
                    e = pending_pts.pop_front();
                    if (pt !== e) begin
                        n_err++;
                        if (n_mism++ < 10)
                            $display("point mismatch exp %p got %p", e, pt);
                    end
                end
            end
            if (recv_hold)
                pt_ready <= 1'b0;
            else
                pt_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // long output hold-off, counted here
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            recv_hold   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            recv_hold <= 1'b0;
        end
    end

    // watchdog on cycles without any accepted request or point
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (pt_valid && pt_ready) || !rst_n || recv_hold)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // directed rows: type, ctrl1, ctrl2, end, expected point for single-point rows
    typedef struct {
        t_req r;
        bit   has_exp;
        t_pt  exp;
    } t_row;

    function automatic t_row mk_row(logic [1:0] ty, int c1x, int c1y, int c2x, int c2y,
                                    int ex, int ey, bit has_e);
        t_row w;
        w.r = '{ty, COORD_W'(c1x), COORD_W'(c1y), COORD_W'(c2x), COORD_W'(c2y),
                COORD_W'(ex), COORD_W'(ey)};
        w.has_exp = has_e;
        w.exp = '{(ty == REQ_LINE), COORD_W'(ex), COORD_W'(ey), 1'b0, 1'b1};
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_row rows[$];
        t_row extra;
        int   span;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        pt_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        recv_hold = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        n_err = 0;
        n_mism = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mdl_conic_step = STEP_RESET;
        mdl_cubic_step = STEP_RESET;
        mdl_pen_x = '0;
        mdl_pen_y = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, all types, short/long curves, unused control points
        rows.push_back(mk_row(REQ_QUAD, 10, 10, 0, 0, 20, 0, 0));           // short from reset pen
        rows.push_back(mk_row(REQ_MOVE, 5, 5, 7, 7, 8388607, 8388607, 1));
        rows.push_back(mk_row(REQ_LINE, -1, 3, 9, 9, -8388608, -8388608, 1));
        rows.push_back(mk_row(REQ_LINE, 0, 0, 0, 0, 8388607, -8388608, 1));
        rows.push_back(mk_row(REQ_CUBIC, -8388608, 8388607, 8388607, -8388608,
                              0, 0, 0));                                  // long, saturated
        rows.push_back(mk_row(REQ_QUAD, 8388607, 8388607, -5, 5, -8388608, 0, 0));
        rows.push_back(mk_row(REQ_MOVE, 0, 0, 0, 0, 0, 0, 1));
        rows.push_back(mk_row(REQ_CUBIC, 0, 0, 0, 0, 0, 0, 0));             // degenerate
        rows.push_back(mk_row(REQ_CUBIC, 100, 300, 500, -300, 600, 0, 0));
        rows.push_back(mk_row(REQ_QUAD, 3000, 3000, 1, 1, 6000, 0, 0));
        rows.push_back(mk_row(REQ_QUAD, 2, -3, 99, 99, 1, 1, 0));           // ctrl2 ignored
        rows.push_back(mk_row(REQ_LINE, -1, -1, -1, -1, -1, -1, 1));
        foreach (rows[i]) begin
            send_request(rows[i].r);
            if (rows[i].has_exp && pending_pts.size() > 0 &&
                pending_pts[$] !== rows[i].exp) begin
                n_err++;
                $display("model disagrees with directed row %0d", i);
            end
        end
        wait_drained();

        // zero step and unknown index
        write_step(CFG_CONIC, '0);
        write_step(CFG_CUBIC, '0);
        write_step(CFG_W'(2), 16'd7);
        write_step(CFG_W'(255), 16'd7);
        extra = mk_row(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0);
        send_request(extra.r);
        extra = mk_row(REQ_QUAD, 30, 0, 0, 0, 30, 30, 0);
        send_request(extra.r);
        extra = mk_row(REQ_CUBIC, 1, 2, 3, 4, 5, 6, 0);
        send_request(extra.r);
        wait_drained();

        // random phases across settings and idle profiles
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_step(CFG_CONIC, 16'd1);     write_step(CFG_CUBIC, 16'd65535); end
                1: begin write_step(CFG_CONIC, 16'd65535); write_step(CFG_CUBIC, 16'd1);     end
                2: begin write_step(CFG_CONIC, 16'd200);   write_step(CFG_CUBIC, 16'd50);    end
                default: begin
                    write_step(CFG_CONIC, STEP_W'($urandom_range(1, 2000)));
                    write_step(CFG_CUBIC, STEP_W'($urandom_range(1, 2000)));
                end
            endcase
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 48 : 0;
            recv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 34 : 0;
            if (ph == 2) hold_cycles = 3000;
            for (int i = 0; i < 72; i++) begin
                span = ($urandom_range(3) == 0) ? 20000 : 600;
                send_request(rand_request(span));
                if (i == 36) begin
                    // pause until the flattener has caught up
                    req_valid <= 1'b0;
                    while (pending_pts.size() != 0) @(posedge clk);
                end
            end
            wait_drained();
        end

        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
